/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the sprite list decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge while reset is released.
`define SLD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every rising clock edge, reset included.
`define SLD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLD_ASSERT(name, clk, rst_n, prop, msg)
`define SLD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* rtl/sld_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite list decoder package
// Types, constants and helper functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Grid pitch of a block sprite, in pixels.
    localparam int CELL_PIXELS_DEF = 16;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int TILE_W  = 13;
    localparam int COLOR_W = 8;
    localparam int PAL_W   = 9;
    localparam int RAW_W   = 16;
    localparam int POS_W   = 17;
    localparam int ZOOM_W  = 8;
    localparam int BLK_W   = 8;
    localparam int SCALE_W = 17;

    // Stream payload widths.
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 96;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_BASE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SKIP_EMPTY = 1'd1;
    localparam logic [COLOR_W-1:0]    COLOR_BASE_RST = 8'd64;
    localparam logic                  SKIP_EMPTY_RST = 1'b1;

    // Raw position words above this value are negative.
    localparam logic [RAW_W-1:0] RAW_NEG_LIMIT = 16'h8000;

    // Queue entry: one classified sprite word.
    typedef struct packed {
        logic                frame_start;
        logic                emit;
        logic [TILE_W-1:0]   tile;
        logic [PAL_W-1:0]    palette;
        logic                flip_x;
        logic                flip_y;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [ZOOM_W-1:0]   zoom_x;
        logic [ZOOM_W-1:0]   zoom_y;
        logic [BLK_W-1:0]    block_cols;
        logic [BLK_W-1:0]    block_rows;
    } sld_entry_t;

    // Queue status seen by the front part.
    typedef struct packed {
        logic full;
    } sld_queue_stat_t;

    // Raw 16-bit position to signed 17-bit; 0x8000 itself stays positive.
    function automatic logic [POS_W-1:0] raw_to_pos(input logic [RAW_W-1:0] w);
        logic [POS_W-1:0] res;
        res = (w > RAW_NEG_LIMIT) ? {1'b1, w} : {1'b0, w};
        return res;
    endfunction

    // Zoom byte to 1.16 scale; zero means unity.
    function automatic logic [SCALE_W-1:0] zoom_scale(input logic [ZOOM_W-1:0] z);
        logic [ZOOM_W:0]    inv;
        logic [4:0]         steps;
        logic [SCALE_W-1:0] res;
        inv   = 9'h100 - {1'b0, z};
        steps = {1'b0, inv[7:4]} + 5'd1;
        if (z == '0) begin
            res = 17'h10000;
        end else begin
            res = {steps, 12'h000};
        end
        return res;
    endfunction

endpackage

/* rtl/sld_front.sv */
// ----------------------------------------------------------------------------
// Sprite list decoder front part
// Holds the configuration registers, unpacks each input word, drops empty
// entries when skip_empty is set and converts raw positions and colours before queueing.
// ----------------------------------------------------------------------------
module sld_front
    import sld_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   s_tuser,
    input  sld_queue_stat_t        q_stat,
    output logic                   q_push,
    output sld_entry_t             q_entry
);

    logic [COLOR_W-1:0] color_base_reg;
    logic               skip_empty_reg;

    logic [TILE_W-1:0]  tile;
    logic [COLOR_W-1:0] colour;
    logic               drop;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_base_reg <= COLOR_BASE_RST;
            skip_empty_reg <= SKIP_EMPTY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COLOR_BASE: color_base_reg <= cfg_wdata;
                REG_SKIP_EMPTY: skip_empty_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign tile   = s_tdata[12:0];
    assign colour = s_tdata[20:13];

    // An empty entry is dropped, but a frame start still has to reach the
    // back part so that it can clear the block state.
    assign drop     = skip_empty_reg && (tile == '0);
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready && (!drop || s_tuser);

    // Classify and convert the entry.
    always_comb begin
        q_entry.frame_start = s_tuser;
        q_entry.emit        = !drop;
        q_entry.tile        = tile;
        q_entry.palette     = {1'b0, colour} + {1'b0, color_base_reg};
        q_entry.flip_x      = s_tdata[21];
        q_entry.flip_y      = s_tdata[22];
        q_entry.pos_x       = raw_to_pos(s_tdata[38:23]);
        q_entry.pos_y       = raw_to_pos(s_tdata[54:39]);
        q_entry.zoom_x      = s_tdata[62:55];
        q_entry.zoom_y      = s_tdata[70:63];
        q_entry.block_cols  = s_tdata[78:71];
        q_entry.block_rows  = s_tdata[86:79];
    end

endmodule

/* rtl/sld_fifo.sv */
// ----------------------------------------------------------------------------
// Sprite list decoder queue
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sld_fifo
    import sld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sld_entry_t       push_entry,
    output sld_queue_stat_t  stat,
    input  logic             pop,
    output logic             head_valid,
    output sld_entry_t       head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sld_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `SLD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `SLD_ASSERT(a_no_push_full, aclk, aresetn, stat.full |-> !push, "push into full queue")

endmodule

/* rtl/sld_back.sv */
// ----------------------------------------------------------------------------
// Sprite list decoder back part
// Runs the block sprite chaining state, places each entry and drives the
// registered result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sld_back
    import sld_pkg::*;
#(
    parameter int CELL_PIXELS = CELL_PIXELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  sld_entry_t            head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tuser
);

    // Chaining state.
    logic               block_active_reg, block_active_next;
    logic [BLK_W-1:0]   col_index_reg, col_index_next;
    logic [BLK_W-1:0]   row_index_reg, row_index_next;
    logic [BLK_W-1:0]   col_limit_reg, col_limit_next;
    logic [BLK_W-1:0]   row_limit_reg, row_limit_next;
    logic [POS_W-1:0]   anchor_x_reg, anchor_x_next;
    logic [POS_W-1:0]   anchor_y_reg, anchor_y_next;
    logic [ZOOM_W-1:0]  held_zoom_x_reg, held_zoom_x_next;
    logic [ZOOM_W-1:0]  held_zoom_y_reg, held_zoom_y_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [TILE_W-1:0]  out_tile_reg;
    logic [PAL_W-1:0]   out_palette_reg;
    logic               out_flip_x_reg;
    logic               out_flip_y_reg;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [SCALE_W-1:0] scale_x_reg, scale_x_next;
    logic [SCALE_W-1:0] scale_y_reg, scale_y_next;
    logic               in_block_reg, in_block_next;

    logic               eff_active;
    logic [BLK_W-1:0]   eff_col;
    logic [BLK_W-1:0]   eff_row;
    logic               start;
    logic               act;
    logic [BLK_W-1:0]   lim_c;
    logic [BLK_W-1:0]   lim_r;
    logic [BLK_W-1:0]   idx_c;
    logic [BLK_W-1:0]   idx_r;
    logic [POS_W-1:0]   anc_x;
    logic [POS_W-1:0]   anc_y;
    logic [ZOOM_W-1:0]  zm_x;
    logic [ZOOM_W-1:0]  zm_y;
    logic               load;

    // Take the head whenever the result register is free or being drained.
    assign pop  = head_valid && (!out_valid_reg || m_tready);
    assign load = pop && head_entry.emit;

    // Placement and chaining logic for the head entry.
    always_comb begin
        // A frame start clears the chaining state before anything else.
        eff_active = head_entry.frame_start ? 1'b0 : block_active_reg;
        eff_col    = head_entry.frame_start ? '0 : col_index_reg;
        eff_row    = head_entry.frame_start ? '0 : row_index_reg;

        start = ((head_entry.block_cols | head_entry.block_rows) != '0) && !eff_active;
        act   = start || eff_active;

        lim_c = start ? head_entry.block_cols : col_limit_reg;
        lim_r = start ? head_entry.block_rows : row_limit_reg;
        idx_c = start ? '0 : eff_col;
        idx_r = start ? '0 : eff_row;
        anc_x = start ? head_entry.pos_x : anchor_x_reg;
        anc_y = start ? head_entry.pos_y : anchor_y_reg;
        zm_x  = start ? head_entry.zoom_x : held_zoom_x_reg;
        zm_y  = start ? head_entry.zoom_y : held_zoom_y_reg;

        block_active_next = eff_active;
        col_index_next    = eff_col;
        row_index_next    = eff_row;
        col_limit_next    = col_limit_reg;
        row_limit_next    = row_limit_reg;
        anchor_x_next     = anchor_x_reg;
        anchor_y_next     = anchor_y_reg;
        held_zoom_x_next  = held_zoom_x_reg;
        held_zoom_y_next  = held_zoom_y_reg;

        pos_x_next    = head_entry.pos_x;
        pos_y_next    = head_entry.pos_y;
        scale_x_next  = zoom_scale(head_entry.zoom_x);
        scale_y_next  = zoom_scale(head_entry.zoom_y);
        in_block_next = 1'b0;

        if (head_entry.emit && act) begin
            col_limit_next   = lim_c;
            row_limit_next   = lim_r;
            anchor_x_next    = anc_x;
            anchor_y_next    = anc_y;
            held_zoom_x_next = zm_x;
            held_zoom_y_next = zm_y;

            // Grid cell from the anchor.
            pos_x_next    = anc_x + POS_W'(POS_W'(idx_c) * POS_W'(CELL_PIXELS));
            pos_y_next    = anc_y + POS_W'(POS_W'(idx_r) * POS_W'(CELL_PIXELS));
            scale_x_next  = zoom_scale(zm_x);
            scale_y_next  = zoom_scale(zm_y);
            in_block_next = 1'b1;

            // Walk rows first, then columns; past the last column the block ends.
            block_active_next = 1'b1;
            if (idx_r >= lim_r) begin
                row_index_next = '0;
                if (idx_c >= lim_c) begin
                    col_index_next    = '0;
                    block_active_next = 1'b0;
                end else begin
                    col_index_next = idx_c + 1'b1;
                end
            end else begin
                col_index_next = idx_c;
                row_index_next = idx_r + 1'b1;
            end
        end
    end

    // Result valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and chaining registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            block_active_reg <= 1'b0;
            col_index_reg    <= '0;
            row_index_reg    <= '0;
            col_limit_reg    <= '0;
            row_limit_reg    <= '0;
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            held_zoom_x_reg  <= '0;
            held_zoom_y_reg  <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                block_active_reg <= block_active_next;
                col_index_reg    <= col_index_next;
                row_index_reg    <= row_index_next;
                col_limit_reg    <= col_limit_next;
                row_limit_reg    <= row_limit_next;
                anchor_x_reg     <= anchor_x_next;
                anchor_y_reg     <= anchor_y_next;
                held_zoom_x_reg  <= held_zoom_x_next;
                held_zoom_y_reg  <= held_zoom_y_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            out_tile_reg    <= head_entry.tile;
            out_palette_reg <= head_entry.palette;
            out_flip_x_reg  <= head_entry.flip_x;
            out_flip_y_reg  <= head_entry.flip_y;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            scale_x_reg     <= scale_x_next;
            scale_y_reg     <= scale_y_next;
            in_block_reg    <= in_block_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = in_block_reg;
    assign m_tdata  = {4'b0000, scale_y_reg, scale_x_reg, pos_y_reg, pos_x_reg,
                       out_flip_y_reg, out_flip_x_reg, out_palette_reg, out_tile_reg};

    `SLD_ASSERT(a_idle_idx_zero, aclk, aresetn, !block_active_reg |-> (col_index_reg == '0 && row_index_reg == '0), "indices nonzero outside a block")
    `SLD_ASSERT(a_row_in_range, aclk, aresetn, block_active_reg |-> (row_index_reg <= row_limit_reg), "row index past its limit")
    `SLD_ASSERT(a_col_in_range, aclk, aresetn, block_active_reg |-> (col_index_reg <= col_limit_reg), "column index past its limit")
    `SLD_ASSERT(a_hold_stalled, aclk, aresetn, (out_valid_reg && !m_tready) |=> $stable(m_tdata), "stalled result changed")

endmodule

/* rtl/sprite_list_block_decoder.sv */
// ----------------------------------------------------------------------------
// Sprite list block decoder
// Turns sprite table entries into draw commands, chaining block sprites
// onto a grid from an anchor entry.
// ----------------------------------------------------------------------------
// A result passes through the queue and then the result register before
// it is valid. Throughput: one entry per cycle while m_tready does not
// stall the result stream; the back part updates the block state as it
// takes each entry, and a two-entry queue parts the input from the output.
// Empty entries that are dropped give no result.
// Reset (aresetn low, synchronous) empties the queue and result register,
// clears the block state and restores color_base 64 and skip_empty 1.
// ----------------------------------------------------------------------------
module sprite_list_block_decoder
    import sld_pkg::*;
#(
    parameter int CELL_PIXELS = CELL_PIXELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Sprite entries
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tile_code[12:0], colour[20:13], mirror_x[21], mirror_y[22], raw_x[38:23],
    // raw_y[54:39], zoom_x_byte[62:55], zoom_y_byte[70:63], block_cols[78:71],
    // block_rows[86:79], zero[87]
    input  logic [S_DATA_W-1:0]    s_tdata,
    // frame_start[0]
    input  logic                   s_tuser,
    // Draw commands
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_tile[12:0], out_palette[21:13], out_flip_x[22], out_flip_y[23],
    // pos_x[40:24], pos_y[57:41], scale_x[74:58], scale_y[91:75], zero[95:92]
    output logic [M_DATA_W-1:0]    m_tdata,
    // in_block[0]
    output logic                   m_tuser
);

    sld_queue_stat_t q_stat;
    logic            q_push;
    sld_entry_t      q_entry;
    logic            q_pop;
    logic            head_valid;
    sld_entry_t      head_entry;

    sld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    sld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .stat       (q_stat),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    sld_back #(
        .CELL_PIXELS (CELL_PIXELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* dv/sprite_list_block_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite list block decoder testbench
// Streams sprite table entries through the decoder and predicts every draw
// command in a scoreboard. Lists hold single sprites and block sprites that
// walk the cell grid, plus random noise. Both stream sides idle at random,
// and the configuration changes between phases once every expected command has come out.
// ----------------------------------------------------------------------------
module sprite_list_block_decoder_tb;
    import sld_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 160;

    // One sprite table entry as the sender sees it.
    typedef struct packed {
        bit        fs;
        bit [12:0] tile;
        bit [7:0]  colour;
        bit        mx;
        bit        my;
        bit [15:0] rx;
        bit [15:0] ry;
        bit [7:0]  zx;
        bit [7:0]  zy;
        bit [7:0]  bc;
        bit [7:0]  br;
    } sprite_entry_t;

    // One draw command as the receiver sees it.
    typedef struct packed {
        bit [12:0] tile;
        bit [8:0]  palette;
        bit        flip_x;
        bit        flip_y;
        bit [16:0] pos_x;
        bit [16:0] pos_y;
        bit [16:0] scale_x;
        bit [16:0] scale_y;
        bit        in_block;
    } draw_cmd_t;

    // Predicts draw commands from accepted entries and checks the results.
    class draw_scoreboard;
        bit [7:0]  color_base;
        bit        skip_empty;
        bit        blk_active;
        bit [7:0]  col_idx;
        bit [7:0]  row_idx;
        bit [7:0]  col_lim;
        bit [7:0]  row_lim;
        bit [16:0] anchor_x;
        bit [16:0] anchor_y;
        bit [7:0]  held_zx;
        bit [7:0]  held_zy;
        draw_cmd_t expected_cmds[$];
        int        fails;

        function new();
            color_base = COLOR_BASE_RST;
            skip_empty = SKIP_EMPTY_RST;
            blk_active = 1'b0;
            col_idx    = '0;
            row_idx    = '0;
            col_lim    = '0;
            row_lim    = '0;
            anchor_x   = '0;
            anchor_y   = '0;
            held_zx    = '0;
            held_zy    = '0;
            fails      = 0;
        endfunction

        function void write_reg(bit [CFG_ADDR_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COLOR_BASE: color_base = val;
                REG_SKIP_EMPTY: skip_empty = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        // Raw words above 0x8000 wrap to negative positions.
        static function bit [16:0] signed_pos(bit [15:0] w);
            int v;
            v = int'(w);
            if (v > 32768) v = v - 65536;
            return 17'(v);
        endfunction

        // Zoom byte to 1.16 scale; zero means unity.
        static function bit [16:0] scale_of(bit [7:0] z);
            int steps;
            if (z == 8'd0) return 17'h10000;
            steps = ((256 - int'(z)) / 16) + 1;
            return 17'(steps * 4096);
        endfunction

        function void note_entry(sprite_entry_t e);
            draw_cmd_t c;
            bit [7:0]  zx;
            bit [7:0]  zy;
            // A new list drops any block in progress, even for a dropped entry.
            if (e.fs) begin
                blk_active = 1'b0;
                col_idx    = '0;
                row_idx    = '0;
            end
            if (skip_empty && e.tile == 13'd0) return;
            c.pos_x    = signed_pos(e.rx);
            c.pos_y    = signed_pos(e.ry);
            c.in_block = 1'b0;
            zx = e.zx;
            zy = e.zy;
            // A nonzero block size outside a block latches a new anchor.
            if ((e.bc | e.br) != 8'd0 && !blk_active) begin
                col_lim    = e.bc;
                row_lim    = e.br;
                col_idx    = '0;
                row_idx    = '0;
                anchor_x   = c.pos_x;
                anchor_y   = c.pos_y;
                held_zx    = e.zx;
                held_zy    = e.zy;
                blk_active = 1'b1;
            end
            // Inside a block the entry takes the next cell, rows first.
            if (blk_active) begin
                c.in_block = 1'b1;
                zx = held_zx;
                zy = held_zy;
                c.pos_x = anchor_x + 17'(int'(col_idx) * CELL_PIXELS_DEF);
                c.pos_y = anchor_y + 17'(int'(row_idx) * CELL_PIXELS_DEF);
                if (row_idx >= row_lim) begin
                    row_idx = '0;
                    if (col_idx >= col_lim) begin
                        col_idx    = '0;
                        blk_active = 1'b0;
                    end else begin
                        col_idx = col_idx + 8'd1;
                    end
                end else begin
                    row_idx = row_idx + 8'd1;
                end
            end
            c.tile    = e.tile;
            c.palette = 9'(e.colour) + 9'(color_base);
            c.flip_x  = e.mx;
            c.flip_y  = e.my;
            c.scale_x = scale_of(zx);
            c.scale_y = scale_of(zy);
            expected_cmds.push_back(c);
        endfunction

        function void compare_field(string field, bit [31:0] want, bit [31:0] seen);
            if (want != seen) begin
                $error("%s: expected %0h, got %0h", field, want, seen);
                fails++;
            end
        endfunction

        function void check_command(bit [M_DATA_W-1:0] data, bit user);
            draw_cmd_t want;
            if (expected_cmds.size() == 0) begin
                $error("draw command with none expected: tdata %h", data);
                fails++;
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("out_tile", 32'(want.tile), 32'(data[12:0]));
            compare_field("out_palette", 32'(want.palette), 32'(data[21:13]));
            compare_field("out_flip_x", 32'(want.flip_x), 32'(data[22]));
            compare_field("out_flip_y", 32'(want.flip_y), 32'(data[23]));
            compare_field("pos_x", 32'(want.pos_x), 32'(data[40:24]));
            compare_field("pos_y", 32'(want.pos_y), 32'(data[57:41]));
            compare_field("scale_x", 32'(want.scale_x), 32'(data[74:58]));
            compare_field("scale_y", 32'(want.scale_y), 32'(data[91:75]));
            compare_field("in_block", 32'(want.in_block), 32'(user));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // tile_code, colour, mirror_x, mirror_y, raw_x, raw_y, zoom_x_byte,
    // zoom_y_byte, block_cols, block_rows, zero pad
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    // frame_start
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // out_tile, out_palette, out_flip_x, out_flip_y, pos_x, pos_y, scale_x,
    // scale_y, zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    // in_block
    logic                  m_tuser;

    draw_scoreboard sb = new();

    int idle_cycles = 0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_tick     = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    bit gaps_on     = 1'b1;
    bit list_head   = 1'b0;

    sprite_list_block_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Note accepted entries and check accepted draw commands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_entry(sprite_entry_t'({s_tuser, s_tdata[12:0], s_tdata[20:13],
                                               s_tdata[21], s_tdata[22], s_tdata[38:23],
                                               s_tdata[54:39], s_tdata[62:55],
                                               s_tdata[70:63], s_tdata[78:71],
                                               s_tdata[86:79]}));
            end
            if (m_tvalid && m_tready) begin
                sb.check_command(m_tdata, m_tuser);
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(10, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= (rx_tick % 3 != 0);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic sprite_entry_t rand_entry();
        sprite_entry_t e;
        e.fs     = 1'b0;
        e.tile   = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom);
        e.colour = 8'($urandom);
        e.mx     = 1'($urandom_range(0, 1));
        e.my     = 1'($urandom_range(0, 1));
        e.rx     = 16'($urandom);
        e.ry     = 16'($urandom);
        e.zx     = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        e.zy     = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        e.bc     = '0;
        e.br     = '0;
        return e;
    endfunction

    function automatic sprite_entry_t mk(bit fs, bit [12:0] tile, bit [15:0] rx,
                                         bit [15:0] ry, bit [7:0] bc, bit [7:0] br);
        sprite_entry_t e;
        e      = rand_entry();
        e.fs   = fs;
        e.tile = tile;
        e.rx   = rx;
        e.ry   = ry;
        e.bc   = bc;
        e.br   = br;
        return e;
    endfunction

    // Offer one entry, with a random gap between bursts when gaps are on, and wait until it is accepted.
    task automatic offer(sprite_entry_t e);
        int gap;
        if (list_head) begin
            e.fs      = 1'b1;
            list_head = 1'b0;
        end
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= e.fs;
        s_tdata  <= {1'b0, e.br, e.bc, e.zy, e.zx, e.ry, e.rx, e.my, e.mx, e.colour, e.tile};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop sending and wait until every expected command has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(bit [7:0] cbase, bit skip);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_COLOR_BASE;
        cfg_wdata <= cbase;
        sb.write_reg(REG_COLOR_BASE, cbase);
        @(posedge aclk);
        cfg_addr  <= REG_SKIP_EMPTY;
        cfg_wdata <= CFG_DATA_W'(skip);
        sb.write_reg(REG_SKIP_EMPTY, CFG_DATA_W'(skip));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One sprite list: singles, block sprites with their cells, and noise.
    task automatic run_list();
        sprite_entry_t e;
        int units;
        int kind;
        int cells;
        units     = $urandom_range(1, 10);
        list_head = 1'b1;
        for (int u = 0; u < units; u++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                e    = rand_entry();
                e.fs = ($urandom_range(0, 7) == 0);
                e.bc = 8'($urandom);
                e.br = 8'($urandom);
                offer(e);
            end else if (kind < 55) begin
                e = rand_entry();
                if ($urandom_range(0, 9) == 0) begin
                    e.bc = 8'($urandom_range(0, 7));
                    e.br = 8'($urandom_range(0, 7));
                end else begin
                    e.bc = 8'($urandom_range(0, 3));
                    e.br = 8'($urandom_range(0, 3));
                end
                if (e.bc == 8'd0 && e.br == 8'd0) e.br = 8'd1;
                cells = (int'(e.bc) + 1) * (int'(e.br) + 1);
                offer(e);
                // Later cells carry random block words that must be ignored.
                for (int c = 1; c < cells; c++) begin
                    e = rand_entry();
                    if ($urandom_range(0, 3) == 0) begin
                        e.bc = 8'($urandom);
                        e.br = 8'($urandom);
                    end
                    offer(e);
                end
            end else begin
                offer(rand_entry());
            end
        end
    endtask

    initial begin
        sprite_entry_t e;
        bit [7:0] phase_base [5] = '{8'd255, 8'd0, 8'd128, 8'd64, 8'd0};
        bit       phase_skip [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        int       phase_end;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed entries under the reset configuration.
        e = mk(1'b1, 13'h1FFF, 16'h8000, 16'h8001, 8'd0, 8'd0);
        e.colour = 8'hFF;
        e.mx = 1'b1;
        e.my = 1'b1;
        e.zx = 8'h00;
        e.zy = 8'hFF;
        offer(e);
        e = mk(1'b0, 13'd1, 16'hFFFF, 16'h7FFF, 8'd0, 8'd0);
        e.colour = 8'h00;
        e.mx = 1'b0;
        e.my = 1'b0;
        e.zx = 8'h01;
        e.zy = 8'h80;
        offer(e);
        // Empty entry is dropped.
        offer(mk(1'b0, 13'd0, 16'h0000, 16'h0000, 8'd0, 8'd0));
        // Block of two columns by three rows; its zoom bytes are held.
        e = mk(1'b0, 13'd5, 16'h7FFF, 16'hFFF0, 8'd1, 8'd2);
        e.zx = 8'h40;
        e.zy = 8'h10;
        offer(e);
        offer(mk(1'b0, 13'd6, 16'h1234, 16'h5678, 8'hFF, 8'hFF));
        offer(mk(1'b0, 13'd0, 16'h4321, 16'h8765, 8'd3, 8'd3));
        for (int i = 7; i <= 10; i++) begin
            offer(mk(1'b0, 13'(i), 16'($urandom), 16'($urandom), 8'd0, 8'd0));
        end
        offer(mk(1'b0, 13'd11, 16'h0000, 16'h0000, 8'd0, 8'd0));
        // Largest block, cut short by a new list on a dropped entry.
        offer(mk(1'b0, 13'd12, 16'h8000, 16'h8000, 8'hFF, 8'hFF));
        offer(mk(1'b0, 13'd13, 16'h0001, 16'h0002, 8'd0, 8'd0));
        offer(mk(1'b0, 13'd14, 16'h0003, 16'h0004, 8'd0, 8'd0));
        offer(mk(1'b1, 13'd0, 16'h0005, 16'h0006, 8'd0, 8'd0));
        // One row of three columns.
        offer(mk(1'b0, 13'd16, 16'h0010, 16'h0020, 8'd2, 8'd0));
        offer(mk(1'b0, 13'd17, 16'h0000, 16'h0000, 8'd0, 8'd0));
        offer(mk(1'b0, 13'd18, 16'h0000, 16'h0000, 8'd0, 8'd0));
        // One column of two rows, then a new list that starts its own block.
        offer(mk(1'b0, 13'd19, 16'hFFF8, 16'h8001, 8'd0, 8'd1));
        offer(mk(1'b1, 13'd20, 16'hC000, 16'h3FFF, 8'd0, 8'd3));
        for (int i = 21; i <= 23; i++) begin
            offer(mk(1'b0, 13'(i), 16'($urandom), 16'($urandom), 8'd0, 8'd0));
        end

        // Random phases, each under its own register setting.
        phase_base[4] = 8'($urandom);
        phase_skip[4] = 1'($urandom_range(0, 1));
        for (int p = 0; p < 5; p++) begin
            drain_results();
            write_regs(phase_base[p], phase_skip[p]);
            gaps_on = (p != 1);
            // Long receiver hold-off while the sender keeps offering.
            if (p == 1) hold_seq <= hold_seq + 1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_list();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        #1;
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
